FILE: design/assert_macros.svh
// Assertion macros shared by the ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising clock edge outside reset.
`define OLRB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cond never holds at a rising clock edge outside reset.
`define OLRB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/olrb_pkg.sv
// Package with the word types, constants and control structs of the ring buffer.
`default_nettype none
package olrb_pkg;

  localparam int unsigned OLRB_DEPTH    = 4096;
  localparam int unsigned OLRB_MAX_LINE = 64;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned FILL_W        = 13;
  localparam logic [7:0]  NEWLINE_BYTE  = 8'h0A;
  localparam logic        OP_WRITE      = 1'b0;
  localparam logic        OP_READ       = 1'b1;

  typedef struct packed {
    logic             op;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] max_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_write;
    logic accept_read;
    logic issue_rd;
    logic take_byte;
    logic emit_mid;
    logic emit_last;
  } olrb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic limit_hit;
    logic pend_valid;
    logic pend_nl;
    logic byte_zero;
    logic out_free;
  } olrb_status_t;

endpackage
`default_nettype wire

FILE: design/olrb_ctrl.sv
// Controller state machine that sequences byte writes and line reads.
`default_nettype none
module olrb_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_op_i,
  input  olrb_pkg::olrb_status_t status_i,
  output logic                  in_stall_o,
  output olrb_pkg::olrb_cmd_t    cmd_o
);
  import olrb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EVAL = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   finish;

  assign in_stall_o = (state_q != ST_IDLE);
  assign finish = status_i.empty || status_i.limit_hit || status_i.pend_nl;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_READ) begin
            cmd_o.accept_read = 1'b1;
            state_d = ST_SCAN;
          end else begin
            cmd_o.accept_write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (finish) begin
          if (status_i.out_free) begin
            cmd_o.emit_last = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.issue_rd = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // A nonzero byte pushes out the held one, which is then known not to be last.
        if (status_i.byte_zero) begin
          state_d = ST_SCAN;
        end else if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.take_byte = 1'b1;
          cmd_o.emit_mid  = status_i.pend_valid;
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/olrb_datapath.sv
// Datapath with the byte store, pointers, fill count, held byte and output register.
`default_nettype none
module olrb_datapath #(
  parameter int unsigned DEPTH    = olrb_pkg::OLRB_DEPTH,
  parameter int unsigned MAX_LINE = olrb_pkg::OLRB_MAX_LINE
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  olrb_pkg::in_item_t     in_data_i,
  input  olrb_pkg::olrb_cmd_t    cmd_i,
  output olrb_pkg::olrb_status_t status_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output olrb_pkg::out_item_t    out_data_o
);
  import olrb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       mem_q [DEPTH];
  logic [7:0]       rdata_q;
  logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_next;
  logic [CNT_W-1:0] used_q, pend_fill_q;
  logic [LEN_W-1:0] limit_q, count_q, limit_d;
  logic [7:0]       pend_byte_q;
  logic             pend_valid_q;
  logic             full;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [CNT_W+FILL_W-1:0] used_ext, pend_ext;

  assign full        = (used_q == CNT_W'(DEPTH));
  assign wr_ptr_next = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
  assign limit_d     = (in_data_i.max_len > LEN_W'(MAX_LINE)) ? LEN_W'(MAX_LINE)
                                                               : in_data_i.max_len;
  assign used_ext    = {{FILL_W{1'b0}}, used_q};
  assign pend_ext    = {{FILL_W{1'b0}}, pend_fill_q};

  assign status_o.empty      = (used_q == '0);
  assign status_o.limit_hit  = (count_q == limit_q);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.pend_nl    = pend_valid_q && (pend_byte_q == NEWLINE_BYTE);
  assign status_o.byte_zero  = (rdata_q == 8'h00);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_write) begin
      mem_q[wr_ptr_q] <= in_data_i.data_byte;
    end
    if (cmd_i.issue_rd) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      used_q       <= '0;
      limit_q      <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept_write) begin
        wr_ptr_q <= wr_ptr_next;
        // A write into a full store drops the oldest byte.
        if (full) begin
          rd_ptr_q <= wr_ptr_next;
        end else begin
          used_q <= used_q + CNT_W'(1);
        end
      end
      if (cmd_i.accept_read) begin
        limit_q      <= limit_d;
        count_q      <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.issue_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
        used_q   <= used_q - CNT_W'(1);
      end
      if (cmd_i.take_byte) begin
        pend_valid_q <= 1'b1;
        count_q      <= count_q + LEN_W'(1);
      end
      if (cmd_i.emit_last) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.emit_mid || cmd_i.emit_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      pend_byte_q <= rdata_q;
      pend_fill_q <= used_q;
    end
    if (cmd_i.emit_mid) begin
      out_q.out_byte   <= pend_byte_q;
      out_q.byte_valid <= 1'b1;
      out_q.last       <= 1'b0;
      out_q.fill_level <= pend_ext[FILL_W-1:0];
    end else if (cmd_i.emit_last) begin
      out_q.out_byte   <= pend_valid_q ? pend_byte_q : 8'h00;
      out_q.byte_valid <= pend_valid_q;
      out_q.last       <= 1'b1;
      out_q.fill_level <= used_ext[FILL_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: design/overwriting_line_ring_buffer.sv
// Top level of the overwriting line ring buffer: controller plus datapath.
// A byte write leaves the controller idle, so the next word is accepted in the following cycle.
// A line read moves the controller from idle to scan; each stored byte it consumes, zero bytes
// included, is read in the scan state and evaluated in the evaluate state, and the final word
// is emitted from the scan state on the way back to idle. A stall on the output register holds
// the controller in the state that would emit a word. Reset clears the pointers, the fill count
// and the control state; the byte store holds unknown data until written.
`default_nettype none
`include "assert_macros.svh"
module overwriting_line_ring_buffer #(
  parameter int unsigned DEPTH    = olrb_pkg::OLRB_DEPTH,
  parameter int unsigned MAX_LINE = olrb_pkg::OLRB_MAX_LINE
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  olrb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output olrb_pkg::out_item_t out_data_o
);
  import olrb_pkg::*;

  olrb_cmd_t    cmd;
  olrb_status_t status;

  olrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  olrb_datapath #(
    .DEPTH    (DEPTH),
    .MAX_LINE (MAX_LINE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `OLRB_ASSERT(a_read_needs_data, clk_i, rst_ni,
               cmd.issue_rd |-> !status.empty, "store read while empty")
  `OLRB_ASSERT(a_emit_needs_slot, clk_i, rst_ni,
               (cmd.emit_mid || cmd.emit_last) |-> status.out_free, "output word overwritten")
  `OLRB_ASSERT(a_ready_after_line, clk_i, rst_ni,
               cmd.emit_last |=> !in_stall_o, "not ready after a line ended")

endmodule
`default_nettype wire
